// ===== hw/rtl/ixfr_pkg.sv =====
package ixfr_pkg;

  localparam int DNUM_W = 16;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    PH_FIRST     = 3'd0,
    PH_SECOND    = 3'd1,
    PH_REMOVALS  = 3'd2,
    PH_ADDITIONS = 3'd3,
    PH_AXFR      = 3'd4,
    PH_SKIP      = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    CLS_IGNORED  = 2'd0,
    CLS_REMOVAL  = 2'd1,
    CLS_ADDITION = 2'd2,
    CLS_AXFR     = 2'd3
  } cls_t;

  typedef enum logic [2:0] {
    ERR_OK             = 3'd0,
    ERR_BAD_START_SOA  = 3'd1,
    ERR_REM_UNTERM     = 3'd2,
    ERR_BAD_REM_END    = 3'd3,
    ERR_ADD_UNTERM     = 3'd4,
    ERR_BAD_ADD_END    = 3'd5,
    ERR_SERIAL_MISMATCH = 3'd6,
    ERR_TRAILING       = 3'd7
  } err_t;

  typedef enum logic {
    REG_PRIMARY_SERIAL  = 1'b0,
    REG_PRIMARY_PRESENT = 1'b1
  } reg_idx_t;

  // One classified record: optional label of the held first record, then its own label.
  typedef struct packed {
    logic              lead_v;
    cls_t              lead_cls;
    logic              about;
    cls_t              cls;
    logic [DNUM_W-1:0] dn;
    logic              cmp;
    err_t              err;
    logic              fin;
  } entry_t;

endpackage

// ===== hw/rtl/ixfr_chan_if.sv =====
interface ixfr_in_if;
  logic        valid;
  logic        ready;
  logic        record_is_soa;
  logic        soa_decodes;
  logic [31:0] soa_serial;
  logic        end_of_transfer;

  modport source (output valid, record_is_soa, soa_decodes, soa_serial, end_of_transfer,
                  input ready);
  modport sink (input valid, record_is_soa, soa_decodes, soa_serial, end_of_transfer,
                output ready);
endinterface

interface ixfr_out_if;
  logic        valid;
  logic        ready;
  logic        about_first_record;
  logic [1:0]  record_class;
  logic [15:0] delta_number;
  logic        delta_complete;
  logic [2:0]  error_code;
  logic        transfer_finished;
  logic        last_of_run;

  modport source (output valid, about_first_record, record_class, delta_number,
                  delta_complete, error_code, transfer_finished, last_of_run,
                  input ready);
  modport sink (input valid, about_first_record, record_class, delta_number,
                delta_complete, error_code, transfer_finished, last_of_run,
                output ready);
endinterface

interface ixfr_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ixfr_front.sv =====
module ixfr_front #(
  parameter int DELTA_COUNT_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  ixfr_in_if.sink         in_ch,
  ixfr_cfg_if.sink        cfg_ch,
  input  logic            q_full,
  output logic            q_push,
  output ixfr_pkg::entry_t q_entry
);
  import ixfr_pkg::*;

  logic [31:0]                 pserial_r;
  logic                        ppresent_r;
  phase_t                      phase_r, phase_nxt;
  logic [31:0]                 target_r, target_nxt;
  logic [DELTA_COUNT_BITS-1:0] delta_r, delta_nxt;
  err_t                        sticky_r, sticky_nxt;

  logic        soa, dec, eot, ser_is_primary, ser_is_target, accept;
  logic [31:0] ser;
  logic        emit, lead_v, about, cmp, stop, was_skip, cmp_q;
  cls_t        lead_cls, cls, cls_q;
  err_t        newerr;
  logic        content_err, delta_inc;

  assign soa = in_ch.record_is_soa;
  assign dec = in_ch.soa_decodes;
  assign ser = in_ch.soa_serial;
  assign eot = in_ch.end_of_transfer;
  assign ser_is_primary = (ser == pserial_r);
  assign ser_is_target  = (ser == target_r);

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pserial_r  <= '0;
      ppresent_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_PRIMARY_SERIAL:  pserial_r  <= cfg_ch.data;
        REG_PRIMARY_PRESENT: ppresent_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Classification of the current record.
  always_comb begin
    emit = 1'b1; lead_v = 1'b0; lead_cls = CLS_IGNORED; about = 1'b0;
    cls = CLS_IGNORED; cmp = 1'b0; newerr = ERR_OK; stop = 1'b0; was_skip = 1'b0;
    delta_inc = 1'b0;
    unique case (phase_r)
      PH_FIRST: begin
        about = 1'b1;
        if (!ppresent_r) stop = 1'b1;
        else if (!eot) emit = 1'b0;
      end
      PH_SECOND: begin
        lead_v = 1'b1;
        if (!soa) begin
          lead_cls = CLS_AXFR; cls = CLS_AXFR;
        end else if (!dec) begin
          newerr = ERR_BAD_START_SOA;
        end else if (ser_is_primary) begin
          if (eot) begin
            lead_cls = CLS_AXFR; cls = CLS_AXFR;
          end else begin
            stop = 1'b1;
          end
        end else begin
          cls = CLS_REMOVAL;
          if (eot) newerr = ERR_REM_UNTERM;
        end
      end
      PH_REMOVALS: begin
        if (!soa) begin
          cls = CLS_REMOVAL;
          if (eot) newerr = ERR_REM_UNTERM;
        end else if (!dec) begin
          newerr = ERR_BAD_REM_END;
        end else begin
          cls = CLS_ADDITION;
          if (eot) newerr = ERR_ADD_UNTERM;
        end
      end
      PH_ADDITIONS: begin
        if (!soa) begin
          cls = CLS_ADDITION;
          if (eot) newerr = ERR_ADD_UNTERM;
        end else if (!dec) begin
          newerr = ERR_BAD_ADD_END;
        end else if (!ser_is_target) begin
          newerr = ERR_SERIAL_MISMATCH;
        end else if (ser_is_primary && !eot) begin
          newerr = ERR_TRAILING;
        end else begin
          cls = CLS_ADDITION; cmp = 1'b1; delta_inc = 1'b1;
          if (!ser_is_primary && eot) newerr = ERR_REM_UNTERM;
        end
      end
      PH_AXFR: cls = CLS_AXFR;
      default: was_skip = 1'b1;
    endcase
  end

  // Content faults drop the record's own label; unterminated-section faults keep it.
  assign content_err = (newerr != ERR_OK) && (newerr != ERR_REM_UNTERM) &&
                       (newerr != ERR_ADD_UNTERM);
  assign cls_q = content_err ? CLS_IGNORED : cls;
  assign cmp_q = content_err ? 1'b0 : cmp;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_FIRST:  phase_nxt = ppresent_r ? PH_SECOND : PH_SKIP;
      PH_SECOND: begin
        if (!soa) phase_nxt = PH_AXFR;
        else if (ser_is_primary) phase_nxt = PH_SKIP;
        else phase_nxt = PH_REMOVALS;
      end
      PH_REMOVALS:  if (soa && dec) phase_nxt = PH_ADDITIONS;
      PH_ADDITIONS: if (soa && dec && ser_is_target && !ser_is_primary) phase_nxt = PH_REMOVALS;
      default: ;
    endcase
    if (newerr != ERR_OK) phase_nxt = PH_SKIP;
    if (eot) phase_nxt = PH_FIRST;
  end

  always_comb begin
    target_nxt = target_r;
    delta_nxt  = delta_r;
    sticky_nxt = sticky_r;
    if (phase_r == PH_REMOVALS && soa && dec) target_nxt = ser;
    if (delta_inc && !content_err && (delta_r != '1)) delta_nxt = delta_r + 1'b1;
    if (newerr != ERR_OK && sticky_r == ERR_OK) sticky_nxt = newerr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      target_r <= '0;
      delta_r  <= '0;
      sticky_r <= ERR_OK;
    end else if (accept) begin
      phase_r <= phase_nxt;
      if (eot) begin
        target_r <= '0;
        delta_r  <= '0;
        sticky_r <= ERR_OK;
      end else begin
        target_r <= target_nxt;
        delta_r  <= delta_nxt;
        sticky_r <= sticky_nxt;
      end
    end
  end

  assign q_push = accept && emit;

  always_comb begin
    q_entry.lead_v   = lead_v;
    q_entry.lead_cls = lead_cls;
    q_entry.about    = about;
    q_entry.cls      = cls_q;
    q_entry.dn       = DNUM_W'(delta_r);
    q_entry.cmp      = cmp_q;
    q_entry.err      = sticky_nxt;
    q_entry.fin      = stop || (newerr != ERR_OK) || (eot && !was_skip);
  end

endmodule

// ===== hw/rtl/ixfr_queue.sv =====
module ixfr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ixfr_pkg::entry_t wr_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output ixfr_pkg::entry_t head
);
  import ixfr_pkg::*;

  entry_t            slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/ixfr_back.sv =====
module ixfr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  ixfr_pkg::entry_t q_head,
  output logic             q_pop,
  ixfr_out_if.source       out_ch
);
  import ixfr_pkg::*;

  logic              valid_r, valid_nxt;
  logic              half_r, half_nxt;
  logic              about_r, cmp_r, fin_r, last_r;
  cls_t              cls_r;
  logic [DNUM_W-1:0] dn_r;
  err_t              err_r;
  logic              load, take_lead;

  assign load      = !valid_r || out_ch.ready;
  assign take_lead = q_head.lead_v && !half_r;
  assign q_pop     = load && !q_empty && !take_lead;

  always_comb begin
    valid_nxt = valid_r;
    half_nxt  = half_r;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) half_nxt = take_lead;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  // Emit the held first record's label first, then the record's own label.
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      dn_r  <= q_head.dn;
      err_r <= q_head.err;
      if (take_lead) begin
        about_r <= 1'b1;
        cls_r   <= q_head.lead_cls;
        cmp_r   <= 1'b0;
        fin_r   <= 1'b0;
        last_r  <= 1'b0;
      end else begin
        about_r <= q_head.about;
        cls_r   <= q_head.cls;
        cmp_r   <= q_head.cmp;
        fin_r   <= q_head.fin;
        last_r  <= 1'b1;
      end
    end
  end

  assign out_ch.valid              = valid_r;
  assign out_ch.about_first_record = about_r;
  assign out_ch.record_class       = cls_r;
  assign out_ch.delta_number       = dn_r;
  assign out_ch.delta_complete     = cmp_r;
  assign out_ch.error_code         = err_r;
  assign out_ch.transfer_finished  = fin_r;
  assign out_ch.last_of_run        = last_r;

endmodule

// ===== hw/rtl/ixfr_record_sequence_splitter_core.sv =====
// IXFR record splitter: takes one record summary per cycle while the output
// is not stalled, bounded by the output stage's single result per cycle, and
// labels it ignored, removal, addition or whole-zone content, numbering the
// deltas. The front stage updates the transfer phase, target serial, delta
// counter and sticky error per record; a four-entry queue parts it from the
// output stage. With a primary present, a first record that does not end the
// transfer is held; its label comes out with the second record's, which then
// gives two results, and every other record gives one.
// Configuration writes are always accepted and must only occur while idle.
module ixfr_record_sequence_splitter_core #(
  parameter int DELTA_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ixfr_in_if.sink     in_ch,
  ixfr_out_if.source  out_ch,
  ixfr_cfg_if.sink    cfg_ch
);
  import ixfr_pkg::*;

  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_wr, q_head;

  ixfr_front #(.DELTA_COUNT_BITS(DELTA_COUNT_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg_ch  (cfg_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_wr)
  );

  ixfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  ixfr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== hw/rtl/ixfr_chk.sv =====
module ixfr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_about,
  input logic [1:0]  out_class,
  input logic [15:0] out_dn,
  input logic        out_cmp,
  input logic [2:0]  out_err,
  input logic        out_fin,
  input logic        out_last
);
  import ixfr_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_about, out_class, out_dn,
                                                     out_cmp, out_err, out_fin, out_last}))
    else $error("stalled result changed");

  a_lead_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_about && !out_fin && !out_cmp)
    else $error("leading result malformed");

  a_lead_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> (out_class == CLS_IGNORED) || (out_class == CLS_AXFR))
    else $error("leading result has delta class");

  a_cmp_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmp |-> out_class == CLS_ADDITION)
    else $error("delta close on non-addition");

  // The second result of a pair follows with the same error code.
  a_pair_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last &&
                                           out_err == $past(out_err))
    else $error("pair broken");

endmodule

bind ixfr_record_sequence_splitter_core ixfr_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_about (out_ch.about_first_record),
  .out_class (out_ch.record_class),
  .out_dn    (out_ch.delta_number),
  .out_cmp   (out_ch.delta_complete),
  .out_err   (out_ch.error_code),
  .out_fin   (out_ch.transfer_finished),
  .out_last  (out_ch.last_of_run)
);

// ===== dv/ixfr_splitter_tb_pkg.sv =====
`timescale 1ns / 1ps

package ixfr_splitter_tb_pkg;
  import ixfr_pkg::*;

  typedef struct packed {
    logic              about;
    cls_t              cls;
    logic [DNUM_W-1:0] dn;
    logic              cmp;
    err_t              err;
    logic              fin;
    logic              last;
  } label_t;

  class splitter_scoreboard;
    logic [31:0]       primary_serial;
    logic              primary_present;
    phase_t            phase;
    logic [31:0]       target_serial;
    // counter width equals the label width at the default configuration
    logic [DNUM_W-1:0] delta_count;
    err_t              sticky_err;
    label_t            labels_due[$];
    int unsigned       mismatches;

    function new();
      primary_serial  = '0;
      primary_present = 1'b0;
      mismatches      = 0;
      restart_transfer();
    endfunction

    function void restart_transfer();
      phase         = PH_FIRST;
      target_serial = '0;
      delta_count   = '0;
      sticky_err    = ERR_OK;
    endfunction

    function void set_register(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_PRIMARY_SERIAL:  primary_serial = value;
        REG_PRIMARY_PRESENT: primary_present = value[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return labels_due.size();
    endfunction

    function void report_mismatch(string what);
      mismatches++;
      $display("[%0t] MISMATCH %s", $time, what);
    endfunction

    // Label one accepted record; returns 1 unless the record is merely skipped.
    function bit note_record(logic soa, logic dec, logic [31:0] serial, logic eot);
      label_t            lbl;
      bit                lead_v;
      cls_t              lead_cls;
      logic              about;
      cls_t              cls;
      logic              cmp;
      err_t              fresh;
      bit                stop;
      bit                was_skip;
      bit                useful;
      logic [DNUM_W-1:0] dn;
      lead_v   = 1'b0;
      lead_cls = CLS_IGNORED;
      about    = 1'b0;
      cls      = CLS_IGNORED;
      cmp      = 1'b0;
      fresh    = ERR_OK;
      stop     = 1'b0;
      was_skip = 1'b0;
      dn       = delta_count;
      useful   = !(phase == PH_SKIP || (phase == PH_FIRST && !primary_present));
      case (phase)
        PH_FIRST: begin
          about = 1'b1;
          if (!primary_present) begin
            stop  = 1'b1;
            phase = PH_SKIP;
          end else if (!eot) begin
            // hold: the label waits for the second record
            phase = PH_SECOND;
            return useful;
          end
        end
        PH_SECOND: begin
          if (!soa) begin
            lead_v = 1'b1; lead_cls = CLS_AXFR; cls = CLS_AXFR; phase = PH_AXFR;
          end else if (!dec) begin
            lead_v = 1'b1; fresh = ERR_BAD_START_SOA;
          end else if (serial == primary_serial) begin
            lead_v = 1'b1;
            if (eot) begin
              lead_cls = CLS_AXFR; cls = CLS_AXFR;
            end else begin
              stop = 1'b1; phase = PH_SKIP;
            end
          end else begin
            lead_v = 1'b1; cls = CLS_REMOVAL; phase = PH_REMOVALS;
            if (eot) fresh = ERR_REM_UNTERM;
          end
        end
        PH_REMOVALS: begin
          if (!soa) begin
            cls = CLS_REMOVAL;
            if (eot) fresh = ERR_REM_UNTERM;
          end else if (!dec) begin
            fresh = ERR_BAD_REM_END;
          end else begin
            target_serial = serial;
            cls = CLS_ADDITION; phase = PH_ADDITIONS;
            if (eot) fresh = ERR_ADD_UNTERM;
          end
        end
        PH_ADDITIONS: begin
          if (!soa) begin
            cls = CLS_ADDITION;
            if (eot) fresh = ERR_ADD_UNTERM;
          end else if (!dec) begin
            fresh = ERR_BAD_ADD_END;
          end else if (serial != target_serial) begin
            fresh = ERR_SERIAL_MISMATCH;
          end else if (serial == primary_serial && !eot) begin
            fresh = ERR_TRAILING;
          end else begin
            cls = CLS_ADDITION; cmp = 1'b1;
            if (delta_count != {DNUM_W{1'b1}}) delta_count++;
            // a closing SOA that is not the primary opens the next delta
            if (serial != primary_serial) begin
              phase = PH_REMOVALS;
              if (eot) fresh = ERR_REM_UNTERM;
            end
          end
        end
        PH_AXFR: cls = CLS_AXFR;
        default: was_skip = 1'b1;
      endcase

      if (fresh != ERR_OK) begin
        // unterminated-section faults keep the record's own label
        if (fresh != ERR_REM_UNTERM && fresh != ERR_ADD_UNTERM) begin
          cls = CLS_IGNORED;
          cmp = 1'b0;
        end
        if (sticky_err == ERR_OK) sticky_err = fresh;
        phase = PH_SKIP;
        stop  = 1'b1;
      end

      if (lead_v) begin
        lbl = '{about: 1'b1, cls: lead_cls, dn: dn, cmp: 1'b0, err: sticky_err,
                fin: 1'b0, last: 1'b0};
        labels_due = {labels_due, lbl};
      end
      lbl = '{about: about, cls: cls, dn: dn, cmp: cmp, err: sticky_err,
              fin: stop || (eot && !was_skip), last: 1'b1};
      labels_due = {labels_due, lbl};

      if (eot) restart_transfer();
      return useful;
    endfunction

    function void check_result(label_t got);
      label_t want;
      if (labels_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      want = labels_due.pop_front();
      if (got.about !== want.about)
        report_mismatch($sformatf("about_first_record got %b want %b", got.about, want.about));
      if (got.cls !== want.cls)
        report_mismatch($sformatf("record_class got %0d want %0d", got.cls, want.cls));
      if (got.dn !== want.dn)
        report_mismatch($sformatf("delta_number got %0d want %0d", got.dn, want.dn));
      if (got.cmp !== want.cmp)
        report_mismatch($sformatf("delta_complete got %b want %b", got.cmp, want.cmp));
      if (got.err !== want.err)
        report_mismatch($sformatf("error_code got %0d want %0d", got.err, want.err));
      if (got.fin !== want.fin)
        report_mismatch($sformatf("transfer_finished got %b want %b", got.fin, want.fin));
      if (got.last !== want.last)
        report_mismatch($sformatf("last_of_run got %b want %b", got.last, want.last));
    endfunction
  endclass

endpackage

// ===== dv/ixfr_record_sequence_splitter_core_tb.sv =====
`timescale 1ns / 1ps

module ixfr_record_sequence_splitter_core_tb;
  import ixfr_pkg::*;
  import ixfr_splitter_tb_pkg::*;

  localparam int          PHASE_RECORDS = 300;
  localparam int          SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam logic [31:0] DIR_SERIAL    = 32'h5A5A_A5A5;

  typedef struct packed {
    logic        soa;
    logic        dec;
    logic [31:0] serial;
    logic        eot;
  } record_t;

  logic               clk;
  logic               rst_n;
  int unsigned        send_idle_pct;
  int unsigned        take_idle_pct;
  int unsigned        live_records;
  int unsigned        cycles;
  record_t            xfer[$];
  splitter_scoreboard sb;

  ixfr_in_if  in_ch();
  ixfr_out_if out_ch();
  ixfr_cfg_if cfg_ch();

  ixfr_record_sequence_splitter_core #(.DELTA_COUNT_BITS(16)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Result side: throttle ready, check every transfer.
  initial begin
    label_t got;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= take_idle_pct);
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
        got.about = out_ch.about_first_record;
        got.cls   = cls_t'(out_ch.record_class);
        got.dn    = out_ch.delta_number;
        got.cmp   = out_ch.delta_complete;
        got.err   = err_t'(out_ch.error_code);
        got.fin   = out_ch.transfer_finished;
        got.last  = out_ch.last_of_run;
        sb.check_result(got);
      end
    end
  end

  function automatic logic [31:0] pick_serial();
    case ($urandom_range(9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return sb.primary_serial;
      4, 5, 6: return 32'h10 + $urandom_range(3);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] other_serial();
    logic [31:0] s;
    s = pick_serial();
    while (s == sb.primary_serial) s = pick_serial();
    return s;
  endfunction

  function automatic record_t filler(logic soa);
    record_t r;
    r.soa    = soa;
    r.dec    = 1'($urandom_range(1));
    r.serial = soa ? pick_serial() : $urandom();
    r.eot    = 1'b0;
    return r;
  endfunction

  function automatic record_t soa_with(logic [31:0] serial);
    record_t r;
    r.soa    = 1'b1;
    r.dec    = 1'b1;
    r.serial = serial;
    r.eot    = 1'b0;
    return r;
  endfunction

  function automatic void append_record(record_t r);
    xfer = {xfer, r};
  endfunction

  task automatic send_record(input logic soa, input logic dec, input logic [31:0] serial,
                             input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid           = 1'b1;
    in_ch.record_is_soa   = soa;
    in_ch.soa_decodes     = dec;
    in_ch.soa_serial      = serial;
    in_ch.end_of_transfer = eot;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (sb.note_record(soa, dec, serial, eot)) live_records++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Drain, then let a held first record or queued work settle.
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic configure(input logic [31:0] serial, input logic primary_on);
    settle();
    write_register(REG_PRIMARY_SERIAL, serial);
    write_register(REG_PRIMARY_PRESENT, {31'b0, primary_on});
  endtask

  task automatic random_transfer();
    logic [31:0] nxt;
    int          deltas;
    int          pos;
    xfer.delete();
    // first record is only held; its content does not matter
    append_record(filler(1'b1));
    case ($urandom_range(19))
      0, 1: begin
        append_record(filler(1'b0));
        repeat ($urandom_range(6)) append_record(filler(1'($urandom_range(1))));
      end
      2: append_record(soa_with(sb.primary_serial));
      3: begin
        append_record(soa_with(sb.primary_serial));
        repeat ($urandom_range(1, 3)) append_record(filler(1'($urandom_range(1))));
      end
      4, 5: repeat ($urandom_range(1, 6)) append_record(filler(1'($urandom_range(1))));
      default: begin
        append_record(soa_with(other_serial()));
        deltas = ($urandom_range(3) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2);
        for (int i = 0; i < deltas; i++) begin
          repeat ($urandom_range(3)) append_record(filler(1'b0));
          nxt = (i == deltas - 1) ? sb.primary_serial : other_serial();
          append_record(soa_with(nxt));
          repeat ($urandom_range(3)) append_record(filler(1'b0));
          append_record(soa_with(nxt));
        end
        // break a well-formed answer now and then
        if ($urandom_range(99) < 35) begin
          pos = $urandom_range(1, xfer.size() - 1);
          case ($urandom_range(4))
            0: xfer[pos].dec = 1'b0;
            1: xfer[pos].serial = pick_serial();
            2: xfer[pos].soa = ~xfer[pos].soa;
            3: while (xfer.size() > pos + 1) void'(xfer.pop_back());
            default: repeat ($urandom_range(1, 2))
              append_record(filler(1'($urandom_range(1))));
          endcase
        end
      end
    endcase
    xfer[$].eot = 1'b1;
    foreach (xfer[i]) begin
      if ($urandom_range(63) == 0) hold_until_drained();
      send_record(xfer[i].soa, xfer[i].dec, xfer[i].serial, xfer[i].eot);
    end
  endtask

  initial begin
    logic [31:0] phase_serial;
    logic        primary_on;
    int unsigned transfers;
    sb = new();
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.record_is_soa   = 1'b0;
    in_ch.soa_decodes     = 1'b0;
    in_ch.soa_serial      = '0;
    in_ch.end_of_transfer = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = REG_PRIMARY_SERIAL;
    cfg_ch.data           = '0;
    send_idle_pct         = 0;
    take_idle_pct         = 0;
    live_records          = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // primary absent: whole transfer ignored
    configure(DIR_SERIAL, 1'b0);
    send_record(1'b1, 1'b1, DIR_SERIAL, 1'b0);
    send_record(1'b0, 1'b0, 32'h0, 1'b1);
    configure(DIR_SERIAL, 1'b1);
    // first record alone
    send_record(1'b1, 1'b1, DIR_SERIAL, 1'b1);
    // second record not SOA
    send_record(1'b1, 1'b1, DIR_SERIAL, 1'b0);
    send_record(1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0);
    send_record(1'b1, 1'b1, 32'h0, 1'b1);
    // two SOAs, the second at primary serial
    send_record(1'b1, 1'b0, 32'h0, 1'b0);
    send_record(1'b1, 1'b1, DIR_SERIAL, 1'b1);
    // early stop
    send_record(1'b1, 1'b1, DIR_SERIAL, 1'b0);
    send_record(1'b1, 1'b1, DIR_SERIAL, 1'b0);
    send_record(1'b0, 1'b0, 32'h0, 1'b1);
    // two deltas, the first closing SOA opens the second
    send_record(1'b1, 1'b1, DIR_SERIAL, 1'b0);
    send_record(1'b1, 1'b1, 32'h0, 1'b0);
    send_record(1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0);
    send_record(1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
    send_record(1'b0, 1'b0, 32'h0, 1'b0);
    send_record(1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
    send_record(1'b1, 1'b1, DIR_SERIAL, 1'b0);
    send_record(1'b1, 1'b1, DIR_SERIAL, 1'b1);
    // bad start SOA
    send_record(1'b1, 1'b1, DIR_SERIAL, 1'b0);
    send_record(1'b1, 1'b0, DIR_SERIAL, 1'b1);
    // removals cut short
    send_record(1'b1, 1'b1, DIR_SERIAL, 1'b0);
    send_record(1'b1, 1'b1, 32'h7, 1'b0);
    send_record(1'b0, 1'b1, 32'h0, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       phase_serial = 32'h0;
        1:       phase_serial = 32'hFFFF_FFFF;
        4:       phase_serial = 32'h10 + $urandom_range(3);
        default: phase_serial = $urandom();
      endcase
      primary_on = (ph != 3);
      configure(phase_serial, primary_on);
      send_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 60 : 0;
      take_idle_pct = (ph < 2) ? 60 : (ph < 4) ? 31 : 0;
      live_records  = 0;
      transfers     = 0;
      while ((primary_on && live_records < PHASE_RECORDS) || (!primary_on && transfers < 20)) begin
        random_transfer();
        transfers++;
        if (transfers == 10) hold_until_drained();
      end
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
